// ----- hdl/tracking_differentiator_fhan_assert.svh -----
// assertion macros for the tracking differentiator
// expects clk and rst in the scope of each use
`ifndef TRACKING_DIFFERENTIATOR_FHAN_ASSERT_SVH
`define TRACKING_DIFFERENTIATOR_FHAN_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define TDF_ASSERT(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);
`define TDF_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);
`else
`define TDF_ASSERT(label, cond, msg)
`define TDF_ASSERT_NEXT(label, pre, post, msg)
`endif
`endif

// ----- hdl/tdf_pkg.sv -----
// shared types, constants and saturating helpers for the tracking differentiator
// no dependencies
`default_nettype none
package tdf_pkg;
  localparam int SW = 48;
  localparam int SQ_STEPS = 40;
  localparam int DV_STEPS = 32;

  typedef logic signed [SW-1:0] sval_t;

  localparam sval_t SMAX = {1'b0, {(SW-1){1'b1}}};
  localparam sval_t SMIN = {1'b1, {(SW-1){1'b0}}};
  localparam sval_t EPS = 48'sd1;
  localparam sval_t NEG_EPS = -48'sd1;

  localparam logic [1:0] CFG_SPEED = 2'd0;
  localparam logic [1:0] CFG_FILTER = 2'd1;
  localparam logic [1:0] CFG_INTEG = 2'd2;

  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD, OP_D1, OP_D2, OP_A0, OP_Y, OP_S, OP_M1, OP_M2, OP_M3,
    OP_SQ, OP_A, OP_AM, OP_DV0, OP_DV, OP_FH, OP_P, OP_V
  } op_t;

  typedef struct packed {
    logic take;
    op_t  op;
  } cmd_t;

  typedef struct packed {
    logic last;
    logic out_free;
  } sts_t;

  function automatic sval_t sat_add(sval_t a, sval_t b);
    logic signed [SW:0] s;
    s = {a[SW-1], a} + {b[SW-1], b};
    if (s[SW] != s[SW-1]) return s[SW] ? SMIN : SMAX;
    return s[SW-1:0];
  endfunction

  function automatic sval_t sat_sub(sval_t a, sval_t b);
    logic signed [SW:0] s;
    s = {a[SW-1], a} - {b[SW-1], b};
    if (s[SW] != s[SW-1]) return s[SW] ? SMIN : SMAX;
    return s[SW-1:0];
  endfunction

  function automatic logic [SW-1:0] magof(sval_t v);
    return v[SW-1] ? $unsigned(~v) + 48'd1 : $unsigned(v);
  endfunction

  function automatic sval_t from_mag(logic neg, logic [63:0] m);
    logic [63:0] lim;
    lim = {16'd0, 1'b0, {(SW-1){1'b1}}};
    if (m > lim) return neg ? SMIN : SMAX;
    return neg ? -$signed(m[SW-1:0]) : $signed(m[SW-1:0]);
  endfunction

  function automatic logic fsg(sval_t x, sval_t d);
    return (sat_add(x, d) > EPS) && (sat_sub(x, d) < NEG_EPS);
  endfunction
endpackage
`default_nettype wire

// ----- hdl/tracking_differentiator_fhan.sv -----
// top level of the fhan tracking differentiator: stream ports and config port
// depends on tdf_pkg, tdf_ctrl and tdf_dp
// one target beat in, one beat of position, velocity and acceleration out. the
// shared 48x24 multiplier is used in eight steps, the square root of d*(d+8|y|) is
// found two bits a cycle and the quotient r*a/d is found one bit a cycle.
// a new target is taken once the previous one has reached the output register,
// which holds it until the sink takes it; the last step waits while it is held.
// the state and the results are q32.16 and saturate.
`default_nettype none
module tracking_differentiator_fhan import tdf_pkg::*; (
  input  wire  logic         clk,
  input  wire  logic         rst,
  input  wire  logic         s_axis_tvalid,
  output logic               s_axis_tready,
  input  wire  logic [31:0]  s_axis_tdata,  // target
  input  wire  logic         s_axis_tuser,  // target_invalid
  output logic               m_axis_tvalid,
  input  wire  logic         m_axis_tready,
  output logic [143:0]       m_axis_tdata,  // position, velocity, acceleration
  input  wire  logic         cfg_we,
  input  wire  logic [1:0]   cfg_index,
  input  wire  logic [23:0]  cfg_data
);
  cmd_t cmd;
  sts_t sts;

  tdf_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .sts(sts), .cmd(cmd)
  );

  tdf_dp u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .sts(sts),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_target(s_axis_tdata), .in_invalid(s_axis_tuser),
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .out_data(m_axis_tdata)
  );
endmodule
`default_nettype wire

// ----- hdl/tdf_ctrl.sv -----
// sequencer for the fhan step: walks the datapath through one item
// depends on tdf_pkg
`default_nettype none
module tdf_ctrl import tdf_pkg::*; (
  input  wire  logic clk,
  input  wire  logic rst,
  input  wire  logic in_valid,
  output logic       in_ready,
  input  wire  sts_t sts,
  output cmd_t       cmd
);
  typedef enum logic [4:0] {
    S_IDLE, S_LOAD, S_D1, S_D2, S_A0, S_Y, S_S, S_M1, S_M2, S_M3,
    S_SQ, S_A, S_AM, S_DV0, S_DV, S_FH, S_P, S_V
  } state_t;

  state_t state, state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd.take = in_valid && (state == S_IDLE);
    cmd.op = OP_NONE;
    unique case (state)
      S_IDLE: if (in_valid) state_next = S_LOAD;
      S_LOAD: begin cmd.op = OP_LOAD; state_next = S_D1; end
      S_D1:   begin cmd.op = OP_D1; state_next = S_D2; end
      S_D2:   begin cmd.op = OP_D2; state_next = S_A0; end
      S_A0:   begin cmd.op = OP_A0; state_next = S_Y; end
      S_Y:    begin cmd.op = OP_Y; state_next = S_S; end
      S_S:    begin cmd.op = OP_S; state_next = S_M1; end
      S_M1:   begin cmd.op = OP_M1; state_next = S_M2; end
      S_M2:   begin cmd.op = OP_M2; state_next = S_M3; end
      S_M3:   begin cmd.op = OP_M3; state_next = S_SQ; end
      S_SQ: begin
        cmd.op = OP_SQ;
        if (sts.last) state_next = S_A;
      end
      S_A:    begin cmd.op = OP_A; state_next = S_AM; end
      S_AM:   begin cmd.op = OP_AM; state_next = S_DV0; end
      S_DV0:  begin cmd.op = OP_DV0; state_next = S_DV; end
      S_DV: begin
        cmd.op = OP_DV;
        if (sts.last) state_next = S_FH;
      end
      S_FH:   begin cmd.op = OP_FH; state_next = S_P; end
      S_P:    begin cmd.op = OP_P; state_next = S_V; end
      S_V: begin
        if (sts.out_free) begin
          cmd.op = OP_V;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end
endmodule
`default_nettype wire

// ----- hdl/tdf_dp.sv -----
// datapath: config registers, state, shared multiplier, square root and divider
// depends on tdf_pkg and the assertion header
`default_nettype none
`include "tracking_differentiator_fhan_assert.svh"
module tdf_dp import tdf_pkg::*; (
  input  wire  logic         clk,
  input  wire  logic         rst,
  input  wire  cmd_t         cmd,
  output sts_t               sts,
  input  wire  logic         cfg_we,
  input  wire  logic [1:0]   cfg_index,
  input  wire  logic [23:0]  cfg_data,
  input  wire  logic [31:0]  in_target,
  input  wire  logic         in_invalid,
  output logic               out_valid,
  input  wire  logic         out_ready,
  output logic [143:0]       out_data
);
  logic [23:0] speed;
  logic [15:0] h1, h2;
  sval_t x1, x2, tgt, e, a0, y, s, a, fh, pos_new;
  logic [31:0] d;
  logic [71:0] prod, lo;
  logic [79:0] nsq;
  logic [41:0] sq_rem;
  logic [39:0] sq_root;
  logic [32:0] dv_rem;
  logic [31:0] dv_lo, q;
  logic [5:0] cnt;
  logic [47:0] ma;
  logic [23:0] mb;
  sval_t pos_o, vel_o, acc_o;

  sval_t ds, a1, half, a2, a_tmp, y_tmp, step;
  logic [43:0] sq_t, sq_tr;
  logic [33:0] dv_t;
  logic [79:0] nwide;
  logic [40:0] adiff;
  logic [47:0] ym;
  logic fy, fa;

  assign ds = $signed({16'd0, d});
  assign out_data = {acc_o, vel_o, pos_o};
  assign sts.out_free = !out_valid || out_ready;
  assign sts.last = (cmd.op == OP_SQ) ? (cnt == 6'(SQ_STEPS - 1)) : (cnt == 6'(DV_STEPS - 1));

  always_comb begin
    ma = '0;
    mb = '0;
    case (cmd.op)
      OP_LOAD: begin ma = {24'd0, speed}; mb = {8'd0, h1}; end
      OP_D1:   begin ma = {8'd0, prod[39:0]}; mb = {8'd0, h1}; end
      OP_D2:   begin ma = magof(x2); mb = {8'd0, h1}; end
      OP_M1:   begin ma = {16'd0, d}; mb = s[23:0]; end
      OP_M2:   begin ma = {16'd0, d}; mb = s[47:24]; end
      OP_AM:   begin ma = magof(a); mb = speed; end
      OP_FH:   begin ma = magof(x2); mb = {8'd0, h2}; end
      OP_P:    begin ma = magof(fh); mb = {8'd0, h2}; end
      default: ;
    endcase
  end

  always_comb begin
    step = from_mag(1'b0, 64'(prod[71:16]));
    y_tmp = sat_add(e, a0);
    ym = magof(y);
    sq_t = {sq_rem, nsq[79:78]};
    sq_tr = {2'b00, sq_root, 2'b01};
    dv_t = {dv_rem, dv_lo[31]};
    nwide = {prod, 8'd0};
    a1 = $signed({8'd0, sq_root});
    adiff = {1'b0, sq_root} - {9'd0, d};
    half = (a1 > ds) ? $signed({8'd0, adiff[40:1]}) : '0;
    if (y > EPS) a2 = sat_add(a0, half);
    else if (y < NEG_EPS) a2 = sat_sub(a0, half);
    else a2 = a0;
    fy = fsg(y, ds);
    fa = fsg(a, ds);
    a_tmp = fy ? sat_add(a0, y) : a2;
  end

  always_ff @(posedge clk) begin
    // product is held while the last step waits for the output register
    if (cmd.op != OP_NONE) prod <= 72'(ma * mb);
    if (cmd.take) tgt <= in_invalid ? '0 : sval_t'(signed'(in_target));
    case (cmd.op)
      OP_LOAD: e <= sat_sub(x1, tgt);
      OP_D2:   d <= (prod[55:24] == 32'd0) ? 32'd1 : prod[55:24];
      OP_A0:   a0 <= from_mag(x2[47], 64'(prod[71:16]));
      OP_Y:    y <= (y_tmp == '0) ? EPS : y_tmp;
      OP_S: begin
        if (ym > {4'd0, {44{1'b1}}}) s <= SMAX;
        else s <= from_mag(1'b0, 64'(d) + (64'(ym) << 3));
      end
      OP_M2:   lo <= prod;
      OP_M3: begin
        nsq <= 80'(lo) + (80'(prod) << 24);
        sq_rem <= '0;
        sq_root <= '0;
        cnt <= '0;
      end
      OP_SQ: begin
        nsq <= nsq << 2;
        cnt <= cnt + 6'd1;
        if (sq_t >= sq_tr) begin
          sq_rem <= 42'(sq_t - sq_tr);
          sq_root <= {sq_root[38:0], 1'b1};
        end else begin
          sq_rem <= sq_t[41:0];
          sq_root <= {sq_root[38:0], 1'b0};
        end
      end
      OP_A:    a <= (a_tmp == '0) ? EPS : a_tmp;
      OP_DV0: begin
        dv_rem <= nwide[64:32];
        dv_lo <= nwide[31:0];
        q <= '0;
        cnt <= '0;
      end
      OP_DV: begin
        dv_lo <= dv_lo << 1;
        cnt <= cnt + 6'd1;
        if (dv_t >= {2'b00, d}) begin
          dv_rem <= 33'(dv_t - {2'b00, d});
          q <= {q[30:0], 1'b1};
        end else begin
          dv_rem <= dv_t[32:0];
          q <= {q[30:0], 1'b0};
        end
      end
      OP_FH: begin
        if (fa) fh <= from_mag(!a[SW-1], 64'(q));
        else if (a > EPS) fh <= from_mag(1'b1, 64'({speed, 8'd0}));
        else if (a < NEG_EPS) fh <= from_mag(1'b0, 64'({speed, 8'd0}));
        else fh <= '0;
      end
      OP_P:    pos_new <= sat_add(x1, x2[47] ? -step : step);
      OP_V: begin
        x1 <= pos_new;
        x2 <= sat_add(x2, fh[47] ? -step : step);
        pos_o <= pos_new;
        vel_o <= sat_add(x2, fh[47] ? -step : step);
        acc_o <= fh;
      end
      default: ;
    endcase
    if (rst) begin
      x1 <= '0;
      x2 <= '0;
      cnt <= '0;
      out_valid <= 1'b0;
      speed <= 24'd3072000;
      h1 <= 16'd32768;
      h2 <= 16'd328;
    end else begin
      if (cmd.op == OP_V) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_SPEED:  speed <= cfg_data;
          CFG_FILTER: h1 <= cfg_data[15:0];
          CFG_INTEG:  h2 <= cfg_data[15:0];
          default: ;
        endcase
      end
    end
  end

  `TDF_ASSERT_NEXT(a_d_nonzero, cmd.op == OP_D2, d != 32'd0, "divisor d is zero")
  `TDF_ASSERT(a_cnt_range, cnt <= 6'(SQ_STEPS), "iteration count out of range")
  `TDF_ASSERT_NEXT(a_result_shown, cmd.op == OP_V, out_valid, "result not presented")
endmodule
`default_nettype wire

// ----- test/tracking_differentiator_fhan_tb.sv -----
// self-checking testbench for the fhan tracking differentiator
// drives target beats and register writes, predicts position, velocity and acceleration
// depends on tdf_pkg and tracking_differentiator_fhan
`timescale 1ns / 1ps
`default_nettype none
module tracking_differentiator_fhan_tb import tdf_pkg::*; ();

  typedef logic signed [127:0] wide_s;
  typedef struct {
    logic [31:0] target;
    logic        invalid;
  } target_beat_t;
  typedef struct {
    sval_t pos;
    sval_t vel;
    sval_t acc;
  } track_out_t;

  localparam logic [1:0] CFG_UNUSED = 2'd3;
  localparam wide_s WMAX = 128'sh7fff_ffff_ffff;
  localparam wide_s WMIN = -WMAX - 1;
  localparam int LIMIT_CYCLES = 2000000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic s_axis_tuser = 1'b0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [143:0] m_axis_tdata;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [23:0] cfg_data = '0;

  target_beat_t target_fifo[$];
  track_out_t expected_track[$];
  int issued = 0;
  int accepted = 0;
  int gap_left = 0;
  int stall_left = 0;
  int errors = 0;
  int cycles = 0;
  bit no_idle = 1'b0;

  logic [23:0] speed;
  logic [15:0] filt_h;
  logic [15:0] integ_h;
  sval_t pos_state;
  sval_t vel_state;

  tracking_differentiator_fhan i_dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #2 clk = ~clk;

  function automatic sval_t clip(wide_s v);
    if (v > WMAX) return SMAX;
    if (v < WMIN) return SMIN;
    return v[47:0];
  endfunction

  function automatic sval_t add_sat(sval_t a, sval_t b);
    wide_s w;
    w = a;
    w = w + b;
    return clip(w);
  endfunction

  function automatic sval_t sub_sat(sval_t a, sval_t b);
    wide_s w;
    w = a;
    w = w - b;
    return clip(w);
  endfunction

  function automatic logic [63:0] mag(sval_t v);
    wide_s w;
    w = v;
    if (w < 0) w = -w;
    return w[63:0];
  endfunction

  function automatic sval_t signed_of(logic neg, logic [63:0] m);
    wide_s w;
    w = {64'd0, m};
    if (neg) w = -w;
    return clip(w);
  endfunction

  function automatic sval_t scale_step(sval_t x, logic [15:0] h);
    logic [63:0] m;
    logic [63:0] p;
    m = mag(x);
    p = (m >> 16) * h + (((m & 64'hffff) * h) >> 16);
    return signed_of(x < 0, p);
  endfunction

  function automatic int sign_of(sval_t x);
    if (x > EPS) return 1;
    if (x < -EPS) return -1;
    return 0;
  endfunction

  function automatic bit in_band(sval_t x, sval_t d);
    return sign_of(add_sat(x, d)) == 1 && sign_of(sub_sat(x, d)) == -1;
  endfunction

  function automatic logic [63:0] root_of(logic [127:0] n);
    logic [63:0] r;
    logic [127:0] c;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      c = {64'd0, r | (64'd1 << b)};
      if (c * c <= n) r = c[63:0];
    end
    return r;
  endfunction

  function automatic sval_t fhan_accel(sval_t e, sval_t x2, logic [23:0] r, logic [15:0] h);
    logic [63:0] p;
    logic [63:0] ym;
    logic [127:0] n;
    logic [127:0] q;
    sval_t d, a0, y, s, a1, half, a2, a;
    p = r;
    p = (p * h * h) >> 24;
    d = signed_of(1'b0, p);
    if (d < EPS) d = EPS;
    a0 = scale_step(x2, h);
    y = add_sat(e, a0);
    if (mag(y) < EPS) y = EPS;
    ym = mag(y);
    if (ym > 64'(SMAX >>> 3)) s = SMAX;
    else s = signed_of(1'b0, 64'(d) + 8 * ym);
    n = {80'd0, d};
    n = n * {80'd0, s};
    a1 = signed_of(1'b0, root_of(n));
    half = a1 > d ? (a1 - d) >>> 1 : '0;
    case (sign_of(y))
      1: a2 = add_sat(a0, half);
      -1: a2 = sub_sat(a0, half);
      default: a2 = a0;
    endcase
    a = in_band(y, d) ? add_sat(a0, y) : a2;
    if (mag(a) < EPS) a = EPS;
    if (in_band(a, d)) begin
      n = {104'd0, r};
      n = (n * {64'd0, mag(a)}) << 16;
      q = n / ({80'd0, d} << 8);
      return signed_of(a > 0, q[63:0]);
    end
    p = {40'd0, r} << 8;
    case (sign_of(a))
      1: return signed_of(1'b1, p);
      -1: return signed_of(1'b0, p);
      default: return '0;
    endcase
  endfunction

  function automatic track_out_t track_step(target_beat_t t);
    track_out_t o;
    sval_t tgt;
    tgt = t.invalid ? '0 : sval_t'($signed(t.target));
    o.acc = fhan_accel(sub_sat(pos_state, tgt), vel_state, speed, filt_h);
    o.pos = add_sat(pos_state, scale_step(vel_state, integ_h));
    o.vel = add_sat(vel_state, scale_step(o.acc, integ_h));
    pos_state = o.pos;
    vel_state = o.vel;
    return o;
  endfunction

  function automatic int idle_len();
    if (no_idle) return 0;
    if ($urandom_range(0, 15) == 0) return $urandom_range(10, 60);
    if ($urandom_range(0, 2) == 0) return $urandom_range(1, 3);
    return 0;
  endfunction

  // driver
  always @(negedge clk) begin
    logic nv;
    logic [31:0] nd;
    logic nu;
    target_beat_t t;
    nv = s_axis_tvalid;
    nd = s_axis_tdata;
    nu = s_axis_tuser;
    if (!rst && accepted == issued) begin
      nv = 1'b0;
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
      end else if (target_fifo.size() > 0) begin
        t = target_fifo.pop_front();
        nv = 1'b1;
        nd = t.target;
        nu = t.invalid;
        issued <= issued + 1;
        gap_left <= idle_len();
      end
    end
    s_axis_tvalid <= nv;
    s_axis_tdata <= nd;
    s_axis_tuser <= nu;
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      stall_left <= idle_len();
      m_axis_tready <= !rst;
    end
  end

  // monitor and predictor
  always @(posedge clk) begin
    target_beat_t t;
    track_out_t e;
    sval_t got_pos, got_vel, got_acc;
    cycles <= cycles + 1;
    if (!rst && s_axis_tvalid && s_axis_tready) begin
      t.target = s_axis_tdata;
      t.invalid = s_axis_tuser;
      expected_track.push_back(track_step(t));
      accepted <= accepted + 1;
    end
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got_pos = m_axis_tdata[47:0];
      got_vel = m_axis_tdata[95:48];
      got_acc = m_axis_tdata[143:96];
      if (expected_track.size() == 0) begin
        $error("result beat with nothing expected: %h", m_axis_tdata);
        errors++;
      end else begin
        e = expected_track.pop_front();
        if (got_pos !== e.pos) begin
          $error("position: expected %0d, got %0d", e.pos, got_pos);
          errors++;
        end
        if (got_vel !== e.vel) begin
          $error("velocity: expected %0d, got %0d", e.vel, got_vel);
          errors++;
        end
        if (got_acc !== e.acc) begin
          $error("acceleration: expected %0d, got %0d", e.acc, got_acc);
          errors++;
        end
      end
    end
    if (cycles >= LIMIT_CYCLES) begin
      $display("[tracking_differentiator_fhan] ERROR");
      $finish;
    end
  end

  // checked at the rising edge, where the driver's outputs have settled
  task automatic wait_drained();
    @(posedge clk);
    while (target_fifo.size() != 0 || s_axis_tvalid || accepted != issued
           || expected_track.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [23:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    case (idx)
      CFG_SPEED: speed = val;
      CFG_FILTER: filt_h = val[15:0];
      CFG_INTEG: integ_h = val[15:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic push_target(logic [31:0] v, logic inv);
    target_beat_t t;
    t.target = v;
    t.invalid = inv;
    target_fifo.push_back(t);
  endtask

  // mostly held set points with noise, so the tracker settles and then moves
  task automatic push_random(int n);
    logic [31:0] hold;
    hold = $urandom;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4: push_target($urandom, 1'b0);
        5, 6: push_target($urandom, 1'b1);
        7, 8, 9: begin
          hold = $signed($urandom_range(0, 131071)) - 65536;
          push_target(hold, 1'b0);
        end
        10: begin
          hold = $urandom;
          push_target(hold, 1'b0);
        end
        default: push_target(hold + $urandom_range(0, 15) - 8, 1'b0);
      endcase
    end
  endtask

  task automatic run_setting(logic [23:0] r, logic [15:0] h1, logic [15:0] h2, int n);
    write_reg(CFG_SPEED, r);
    write_reg(CFG_FILTER, {8'd0, h1});
    write_reg(CFG_INTEG, {8'd0, h2});
    no_idle = $urandom_range(0, 3) == 0;
    push_random(n / 2);
    wait_drained();
    push_random(n - n / 2);
    wait_drained();
  endtask

  initial begin
    speed = 24'd3072000;
    filt_h = 16'd32768;
    integ_h = 16'd328;
    pos_state = '0;
    vel_state = '0;
    repeat (10) @(negedge clk);
    rst <= 1'b0;

    // directed: extremes, invalid target, tiny errors, full swings
    push_target(32'h0000_0000, 1'b0);
    push_target(32'h7fff_ffff, 1'b0);
    push_target(32'h7fff_ffff, 1'b0);
    push_target(32'h8000_0000, 1'b0);
    push_target(32'h8000_0000, 1'b0);
    push_target(32'hffff_ffff, 1'b1);
    push_target(32'h1234_5678, 1'b1);
    push_target(32'h0000_0001, 1'b0);
    push_target(32'hffff_ffff, 1'b0);
    push_target(32'h0000_0000, 1'b0);
    push_target(32'h0001_0000, 1'b0);
    push_target(32'hffff_0000, 1'b0);
    wait_drained();

    write_reg(CFG_UNUSED, 24'hffffff);
    push_target(32'h0000_0100, 1'b0);
    push_target(32'h0000_0000, 1'b1);
    wait_drained();

    run_setting(24'd3072000, 16'd32768, 16'd328, 220);
    run_setting(24'hffffff, 16'hffff, 16'hffff, 200);
    run_setting(24'd0, 16'd0, 16'd0, 100);
    run_setting(24'd0, 16'hffff, 16'd4000, 100);
    run_setting(24'hffffff, 16'd0, 16'd6000, 100);
    run_setting(24'd1, 16'd1, 16'd1, 100);
    for (int k = 0; k < 5; k++) begin
      run_setting(24'($urandom_range(0, 24'hffffff)), 16'($urandom_range(0, 16'hffff)),
                  16'($urandom_range(0, 16'hffff)), 130);
    end
    run_setting(24'($urandom_range(1000, 400000)), 16'($urandom_range(100, 40000)),
                16'($urandom_range(50, 3000)), 130);

    repeat (200) @(posedge clk);
    if (errors == 0 && expected_track.size() == 0) begin
      $display("[tracking_differentiator_fhan] OK");
    end else begin
      $display("[tracking_differentiator_fhan] ERROR");
    end
    $finish;
  end
endmodule
`default_nettype wire

// ----- sim.f -----
+incdir+hdl
hdl/tdf_pkg.sv
hdl/tdf_ctrl.sv
hdl/tdf_dp.sv
hdl/tracking_differentiator_fhan.sv
test/tracking_differentiator_fhan_tb.sv
